@@ rtl/core/ttps_pkg.sv @@
// Types and constants shared by the transposition table probe/store block.
`default_nettype none

package ttps_pkg;

  localparam int unsigned TT_INDEX_BITS  = 10;
  localparam int unsigned TT_MOVE_BITS   = 32;
  localparam int unsigned TT_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SCORE_PROBE = 2'd0,
    OP_SCORE_STORE = 2'd1,
    OP_MOVE_PROBE  = 2'd2,
    OP_MOVE_STORE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BOUND_NONE  = 2'd0,
    BOUND_EXACT = 2'd1,
    BOUND_UPPER = 2'd2,
    BOUND_LOWER = 2'd3
  } bound_e;

  typedef struct packed {
    op_e                req_type;
    logic [63:0]        pos_key;
    logic [7:0]         search_depth;
    logic signed [15:0] store_score;
    bound_e             bound_kind;
    logic signed [15:0] window_low;
    logic signed [15:0] window_high;
    logic [31:0]        move_word;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] found_score;
    logic [31:0]        found_move;
  } res_t;

  typedef struct packed {
    logic               is_store;
    logic               is_score;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    bound_e             bound;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [31:0]        move;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } back_state_e;

endpackage

`default_nettype wire

@@ rtl/core/ttps_front.sv @@
// Front end: accepts request transactions and classifies them into queue commands.
`default_nettype none

module ttps_front #(
  parameter int unsigned MoveBits = ttps_pkg::TT_MOVE_BITS
) (
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ttps_pkg::req_t in_req_i,
  input  wire logic          clear_busy_i,
  input  wire logic          queue_full_i,
  output logic               push_o,
  output ttps_pkg::cmd_t     cmd_o
);
  import ttps_pkg::*;

  logic [31:0] move_mask;

  assign move_mask  = 32'hFFFF_FFFF >> (32 - MoveBits);
  assign in_ready_o = !queue_full_i && !clear_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.key      = in_req_i.pos_key;
    cmd_o.depth    = in_req_i.search_depth;
    cmd_o.score    = in_req_i.store_score;
    cmd_o.bound    = in_req_i.bound_kind;
    cmd_o.alpha    = in_req_i.window_low;
    cmd_o.beta     = in_req_i.window_high;
    cmd_o.move     = in_req_i.move_word & move_mask;
    unique case (in_req_i.req_type)
      OP_SCORE_PROBE: begin
        cmd_o.is_store = 1'b0;
        cmd_o.is_score = 1'b1;
      end
      OP_SCORE_STORE: begin
        cmd_o.is_store = 1'b1;
        cmd_o.is_score = 1'b1;
      end
      OP_MOVE_PROBE: begin
        cmd_o.is_store = 1'b0;
        cmd_o.is_score = 1'b0;
      end
      OP_MOVE_STORE: begin
        cmd_o.is_store = 1'b1;
        cmd_o.is_score = 1'b0;
      end
      default: begin
        cmd_o.is_store = 1'b0;
        cmd_o.is_score = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/ttps_queue.sv @@
// Short command queue between the front end and the table engine.
`default_nettype none

module ttps_queue #(
  parameter int unsigned Depth = ttps_pkg::TT_QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ttps_pkg::cmd_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output ttps_pkg::cmd_t      rdata_o
);
  import ttps_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ttps_back.sv @@
// Table engine: entry memory, clearing pass, read-modify-write and result register.
`default_nettype none

module ttps_back #(
  parameter int unsigned IndexBits = ttps_pkg::TT_INDEX_BITS,
  parameter int unsigned MoveBits  = ttps_pkg::TT_MOVE_BITS
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           queue_empty_i,
  input  wire ttps_pkg::cmd_t queue_cmd_i,
  output logic                pop_o,
  output logic                clear_busy_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ttps_pkg::res_t      out_res_o
);
  import ttps_pkg::*;

  localparam int unsigned Entries = 2 ** IndexBits;
  localparam int unsigned EntryW  = 64 + 8 + 16 + 2 + MoveBits;

  logic [EntryW-1:0] mem_q [Entries];
  logic [EntryW-1:0] rdata_q;

  back_state_e state_q, state_d;
  logic [IndexBits-1:0] clr_q, clr_d;
  cmd_t cmd_q;
  logic out_valid_q, out_valid_d;
  res_t out_res_q, out_res_d;

  logic [63:0]          e_key;
  logic [7:0]           e_depth;
  logic signed [15:0]   e_score;
  bound_e               e_bound;
  logic [MoveBits-1:0]  e_move;

  logic                 wr_en;
  logic [IndexBits-1:0] wr_addr;
  logic [EntryW-1:0]    wr_data;
  logic                 key_eq;
  logic                 depth_ok;
  logic                 bound_ok;
  logic                 replace;

  assign {e_key, e_depth, e_score, e_bound, e_move} = rdata_q;

  assign clear_busy_o = (state_q == ST_CLEAR);
  assign pop_o        = (state_q == ST_IDLE) && !queue_empty_i
                        && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign out_res_o    = out_res_q;

  assign key_eq   = (e_key == cmd_q.key);
  assign depth_ok = (e_depth >= cmd_q.depth);
  assign replace  = (e_depth <= cmd_q.depth);
  assign bound_ok = (e_bound == BOUND_EXACT)
                    || ((e_bound == BOUND_UPPER) && (e_score <= cmd_q.alpha))
                    || ((e_bound == BOUND_LOWER) && (e_score >= cmd_q.beta));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    wr_en       = 1'b0;
    wr_addr     = cmd_q.key[IndexBits-1:0];
    wr_data     = '0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == {IndexBits{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_res_d   = '0;
        if (cmd_q.is_store) begin
          wr_en = replace;
          if (cmd_q.is_score) begin
            wr_data = {cmd_q.key, cmd_q.depth, cmd_q.score, cmd_q.bound, e_move};
          end else begin
            wr_data = {cmd_q.key, cmd_q.depth, e_score, BOUND_NONE,
                       cmd_q.move[MoveBits-1:0]};
          end
        end else if (cmd_q.is_score) begin
          if (key_eq && depth_ok && bound_ok) begin
            out_res_d.hit         = 1'b1;
            out_res_d.found_score = e_score;
          end
        end else if (key_eq) begin
          out_res_d.hit        = 1'b1;
          out_res_d.found_move = 32'(e_move);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    if (pop_o) begin
      cmd_q <= queue_cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= mem_q[queue_cmd_i.key[IndexBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_rise_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EVAL))
    else $error("result raised without an evaluation cycle");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop_o)
    else $error("queue popped during clearing pass");

  a_eval_write_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && wr_en) |-> cmd_q.is_store)
    else $error("entry written by a probe");

  a_eval_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |=> (state_q == ST_IDLE))
    else $error("evaluation did not return to idle");

  a_slot_free_at_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (!out_valid_q || out_ready_i))
    else $error("result register still occupied at evaluation");
`endif

endmodule

`default_nettype wire

@@ rtl/core/transposition_table_probe_store_top.sv @@
// Path: an accepted request is written into the queue, then the command and entry read registers, then the result.
// The engine handles one command at a time: it pops in ST_IDLE and evaluates in ST_EVAL before the next pop.
// Requests are buffered in a short queue, so input is taken while a result waits.
// Reset: after rst_ni rises a clearing pass zeros all 2**IndexBits entries, one per cycle;
// in_ready_o stays low until the clearing pass is done.
`default_nettype none

module transposition_table_probe_store_top #(
  parameter int unsigned IndexBits  = ttps_pkg::TT_INDEX_BITS,
  parameter int unsigned MoveBits   = ttps_pkg::TT_MOVE_BITS,
  parameter int unsigned QueueDepth = ttps_pkg::TT_QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ttps_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ttps_pkg::res_t      out_res_o
);
  import ttps_pkg::*;

  logic clear_busy;
  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  ttps_front #(
    .MoveBits (MoveBits)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .clear_busy_i (clear_busy),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ttps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .rdata_o (head_cmd)
  );

  ttps_back #(
    .IndexBits (IndexBits),
    .MoveBits  (MoveBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .queue_cmd_i   (head_cmd),
    .pop_o         (pop),
    .clear_busy_o  (clear_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_res_o     (out_res_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the transposition table probe/store block.

module testbench;
  import ttps_pkg::*;

  localparam int unsigned TableSize   = 1 << TT_INDEX_BITS;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned PoolSize    = 12;
  localparam int unsigned LongHold    = 300;
  localparam logic [31:0] MoveMask    = 32'hFFFF_FFFF >> (32 - TT_MOVE_BITS);

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    bound_e             bound;
    logic [31:0]        move;
  } slot_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_res_o;

  slot_t       shadow_table [TableSize];
  res_t        predicted_results [$];
  logic [63:0] key_pool [PoolSize];
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;

  transposition_table_probe_store_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic res_t probe_and_update_table(req_t r);
    logic [TT_INDEX_BITS-1:0] idx;
    slot_t                    e;
    res_t                     res;
    idx = r.pos_key[TT_INDEX_BITS-1:0];
    e   = shadow_table[idx];
    res = '0;
    case (r.req_type)
      OP_SCORE_PROBE: begin
        if (e.key == r.pos_key && e.depth >= r.search_depth) begin
          if (e.bound == BOUND_EXACT ||
              (e.bound == BOUND_UPPER && e.score <= r.window_low) ||
              (e.bound == BOUND_LOWER && e.score >= r.window_high)) begin
            res.hit         = 1'b1;
            res.found_score = e.score;
          end
        end
      end
      OP_SCORE_STORE: begin
        if (e.depth <= r.search_depth) begin
          e.key   = r.pos_key;
          e.depth = r.search_depth;
          e.score = r.store_score;
          e.bound = r.bound_kind;
        end
      end
      OP_MOVE_PROBE: begin
        if (e.key == r.pos_key) begin
          res.hit        = 1'b1;
          res.found_move = e.move & MoveMask;
        end
      end
      default: begin
        if (e.depth <= r.search_depth) begin
          e.key   = r.pos_key;
          e.depth = r.search_depth;
          e.bound = BOUND_NONE;
          e.move  = r.move_word & MoveMask;
        end
      end
    endcase
    shadow_table[idx] = e;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("cycle %0d: mismatch on %s: got 0x%0h, expected 0x%0h",
               cycle_count, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_res_o), '0);
      end else begin
        want = predicted_results.pop_front();
        if (out_res_o.hit !== want.hit) begin
          report_mismatch("hit", 64'(out_res_o.hit), 64'(want.hit));
        end
        if (out_res_o.found_score !== want.found_score) begin
          report_mismatch("found_score", 64'(out_res_o.found_score),
                          64'(want.found_score));
        end
        if (out_res_o.found_move !== want.found_move) begin
          report_mismatch("found_move", 64'(out_res_o.found_move),
                          64'(want.found_move));
        end
      end
    end
  end

  initial begin : ready_driver
    int unsigned stall_left;
    int unsigned mode_left;
    bit          free_run;
    stall_left  = 0;
    mode_left   = 0;
    free_run    = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left   = LongHold;
      end
      if (mode_left == 0) begin
        free_run  = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 250);
      end else begin
        mode_left--;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (free_run) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left  = $urandom_range(8, 40);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic void refresh_key_pool();
    logic [TT_INDEX_BITS-1:0] idx;
    logic [63:0]              key;
    for (int i = 0; i < PoolSize / 3; i++) begin
      idx = TT_INDEX_BITS'($urandom);
      for (int j = 0; j < 3; j++) begin
        key                      = {$urandom, $urandom};
        key[TT_INDEX_BITS-1:0]   = idx;
        key_pool[3 * i + j]      = key;
      end
    end
    if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
  endfunction

  function automatic req_t make_req(op_e op, logic [63:0] key, logic [7:0] depth,
                                    logic signed [15:0] score, bound_e bound,
                                    logic signed [15:0] alpha, logic signed [15:0] beta,
                                    logic [31:0] move);
    req_t r;
    r.req_type     = op;
    r.pos_key      = key;
    r.search_depth = depth;
    r.store_score  = score;
    r.bound_kind   = bound;
    r.window_low   = alpha;
    r.window_high  = beta;
    r.move_word    = move;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.req_type = op_e'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) r.pos_key = key_pool[$urandom_range(0, PoolSize - 1)];
    else r.pos_key = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 97) r.search_depth = 8'($urandom_range(0, 12));
    else r.search_depth = 8'($urandom);
    r.bound_kind = bound_e'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) begin
      r.store_score = 16'($urandom);
      r.window_low  = 16'($urandom);
      r.window_high = 16'($urandom);
    end else begin
      r.store_score = 16'($urandom_range(0, 100) - 50);
      r.window_low  = 16'($urandom_range(0, 100) - 50);
      r.window_high = 16'($urandom_range(0, 100) - 50);
    end
    r.move_word = $urandom;
    return r;
  endfunction

  task automatic send_request(input req_t r, input int unsigned gap);
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_results.push_back(probe_and_update_table(r));
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_cleared_table();
    send_request(make_req(OP_SCORE_PROBE, '0, 8'd0, '0, BOUND_EXACT,
                          16'sh7FFF, 16'sh8000, '0), pick_gap());
    send_request(make_req(OP_MOVE_PROBE, '0, 8'd0, '0, BOUND_NONE, '0, '0, '0), pick_gap());
    send_request(make_req(OP_MOVE_PROBE, 64'h5, 8'd0, '0, BOUND_NONE, '0, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, 64'h1234_0000_0000_0000, 8'd0, '0, BOUND_NONE,
                          '0, '0, '0), pick_gap());
  endtask

  task automatic test_store_probe_rules();
    logic [63:0] k_ones;
    logic [63:0] k_high;
    logic [63:0] k_alias;
    k_ones  = '1;
    k_high  = 64'h8000_0000_0000_0002;
    k_alias = 64'h0000_0001_0000_0002;
    send_request(make_req(OP_SCORE_STORE, k_ones, 8'd255, 16'sh7FFF, BOUND_EXACT,
                          '0, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_ones, 8'd255, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_MOVE_STORE, k_ones, 8'd255, '0, BOUND_EXACT, '0, '0, '1),
                 pick_gap());
    send_request(make_req(OP_MOVE_PROBE, k_ones, 8'd0, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_ones, 8'd0, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_SCORE_STORE, k_ones, 8'd254, '0, BOUND_EXACT, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_SCORE_STORE, k_ones, 8'd255, 16'sh8000, BOUND_UPPER,
                          '0, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_ones, 8'd255, '0, BOUND_NONE,
                          16'sh8000, 16'sh7FFF, '0), pick_gap());
    send_request(make_req(OP_MOVE_PROBE, k_ones, 8'd0, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_SCORE_STORE, k_high, 8'd10, 16'sd100, BOUND_LOWER,
                          '0, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_high, 8'd10, '0, BOUND_NONE,
                          '0, 16'sd100, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_high, 8'd10, '0, BOUND_NONE,
                          '0, 16'sd101, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_high, 8'd11, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_SCORE_STORE, k_high, 8'd10, 16'sd100, BOUND_UPPER,
                          '0, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_high, 8'd3, '0, BOUND_NONE,
                          16'sd99, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_high, 8'd3, '0, BOUND_NONE,
                          16'sd100, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_STORE, k_high, 8'd10, 16'sd100, BOUND_NONE,
                          '0, '0, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_high, 8'd0, '0, BOUND_NONE,
                          16'sh7FFF, 16'sh8000, '0), pick_gap());
    send_request(make_req(OP_SCORE_PROBE, k_alias, 8'd0, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_MOVE_STORE, k_alias, 8'd9, '0, BOUND_NONE, '0, '0,
                          32'h0BAD_F00D), pick_gap());
    send_request(make_req(OP_MOVE_STORE, k_alias, 8'd10, '0, BOUND_NONE, '0, '0,
                          32'h0BAD_F00D), pick_gap());
    send_request(make_req(OP_MOVE_PROBE, k_alias, 8'd0, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
    send_request(make_req(OP_MOVE_PROBE, k_high, 8'd0, '0, BOUND_NONE, '0, '0, '0),
                 pick_gap());
  endtask

  task automatic test_output_backpressure();
    refresh_key_pool();
    hold_requests++;
    for (int n = 0; n < 16; n++) send_request(random_request(), 0);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    bit back_to_back;
    back_to_back = 1'b0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 75 == 0) begin
        wait_for_drain();
        refresh_key_pool();
        back_to_back = ($urandom_range(0, 2) == 0);
      end
      send_request(random_request(), back_to_back ? 0 : pick_gap());
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    foreach (shadow_table[i]) shadow_table[i] = '0;
    refresh_key_pool();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_cleared_table();
    test_store_probe_rules();
    test_output_backpressure();
    test_random_traffic();
    wait_for_drain();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
